>>> hdl/lzssd_pkg.sv
`timescale 1ns / 1ps
package lzssd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 4096;
  localparam int unsigned LANES            = 4;
  localparam int unsigned CMDQ_DEPTH       = 4;
  localparam logic [23:0] LIMIT_RESET      = 24'd65536;

  // command kinds handed from the parser to the copy engine
  localparam logic [1:0] K_NOP   = 2'd0;
  localparam logic [1:0] K_LIT   = 2'd1;
  localparam logic [1:0] K_MATCH = 2'd2;

  // error codes on the result channel
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EARLY = 2'd1;
  localparam logic [1:0] ERR_REF   = 2'd2;
  localparam logic [1:0] ERR_LIMIT = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        first;
    logic        last;
    logic        eos;
    logic [7:0]  data;
    logic [11:0] off;
    logic [8:0]  len;
  } cmd_t;

endpackage

>>> hdl/lzssd_ram.sv
`timescale 1ns / 1ps
module lzssd_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 4096,
  parameter int unsigned AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // read returns the old content on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> hdl/lzssd_front.sv
`timescale 1ns / 1ps
module lzssd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_first,
  input  logic               in_last,
  input  logic               q_ready,
  output logic               q_push,
  output lzssd_pkg::cmd_t    q_cmd
);

  localparam logic [3:0] PH_FLAG1     = 4'd0;
  localparam logic [3:0] PH_FLAG2     = 4'd1;
  localparam logic [3:0] PH_LEN_HI    = 4'd2;
  localparam logic [3:0] PH_LEN_LO    = 4'd3;
  localparam logic [3:0] PH_LITERAL   = 4'd4;
  localparam logic [3:0] PH_SHORT_OFF = 4'd5;
  localparam logic [3:0] PH_WORD_HI   = 4'd6;
  localparam logic [3:0] PH_WORD_LO   = 4'd7;
  localparam logic [3:0] PH_EXTRA_LEN = 4'd8;

  logic [3:0]  ph_r, ph_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [3:0]  cbl_r, cbl_nxt;
  logic [1:0]  plen_r, plen_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [11:0] moff_r, moff_nxt;
  logic        stop_r, stop_nxt;
  logic        stop0, accept, bit_v;
  logic [15:0] w;

  assign in_stall = !q_ready;
  assign accept   = in_valid && q_ready;
  assign w        = {(in_first ? 8'd0 : hi_r), in_byte};

  always_comb begin
    ph_nxt   = in_first ? PH_FLAG1 : ph_r;
    cs_nxt   = in_first ? 8'd0 : cs_r;
    cbl_nxt  = in_first ? 4'd0 : cbl_r;
    plen_nxt = in_first ? 2'd0 : plen_r;
    hi_nxt   = in_first ? 8'd0 : hi_r;
    moff_nxt = in_first ? 12'd0 : moff_r;
    stop0    = in_first ? 1'b0 : stop_r;
    stop_nxt = stop0;
    bit_v    = 1'b0;
    q_cmd       = '0;
    q_cmd.kind  = lzssd_pkg::K_NOP;
    q_cmd.first = in_first;
    q_cmd.last  = in_last;
    q_cmd.data  = in_byte;
    q_push      = accept && !stop0;
    if (!stop0) begin
      case (ph_nxt)
        PH_LITERAL: begin
          q_cmd.kind = lzssd_pkg::K_LIT;
          ph_nxt     = PH_FLAG1;
        end
        PH_SHORT_OFF: begin
          q_cmd.kind = lzssd_pkg::K_MATCH;
          q_cmd.off  = (in_byte == 8'd0) ? 12'd256 : {4'd0, in_byte};
          q_cmd.len  = {7'd0, plen_nxt} + 9'd2;
          ph_nxt     = PH_FLAG1;
        end
        PH_WORD_HI: begin
          hi_nxt = in_byte;
          ph_nxt = PH_WORD_LO;
        end
        PH_WORD_LO: begin
          if (w == 16'd0) begin
            q_cmd.eos = 1'b1;
            ph_nxt    = PH_FLAG1;
          end else begin
            moff_nxt = w[15:4];
            if (w[3:0] == 4'd0) begin
              ph_nxt = PH_EXTRA_LEN;
            end else begin
              q_cmd.kind = lzssd_pkg::K_MATCH;
              q_cmd.off  = w[15:4];
              q_cmd.len  = {5'd0, w[3:0]} + 9'd2;
              ph_nxt     = PH_FLAG1;
            end
          end
        end
        PH_EXTRA_LEN: begin
          q_cmd.kind = lzssd_pkg::K_MATCH;
          q_cmd.off  = moff_nxt;
          q_cmd.len  = {1'b0, in_byte} + 9'd1;
          ph_nxt     = PH_FLAG1;
        end
        default: begin
          cs_nxt  = in_byte;
          cbl_nxt = 4'd8;
        end
      endcase
      // consume flag bits until a byte is needed; at most four in a row
      if (!q_cmd.eos) begin
        for (int i = 0; i < 4; i++) begin
          if (cbl_nxt != 4'd0 && ph_nxt <= PH_LEN_LO) begin
            bit_v   = cs_nxt[0];
            cs_nxt  = {1'b0, cs_nxt[7:1]};
            cbl_nxt = cbl_nxt - 4'd1;
            case (ph_nxt)
              PH_FLAG1:  ph_nxt = bit_v ? PH_FLAG2 : PH_LITERAL;
              PH_FLAG2:  ph_nxt = bit_v ? PH_LEN_HI : PH_WORD_HI;
              PH_LEN_HI: begin
                plen_nxt = {1'b0, bit_v};
                ph_nxt   = PH_LEN_LO;
              end
              default: begin
                plen_nxt = {plen_nxt[0], bit_v};
                ph_nxt   = PH_SHORT_OFF;
              end
            endcase
          end
        end
      end
      stop_nxt = q_cmd.eos || in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_FLAG1;
      cs_r   <= '0;
      cbl_r  <= '0;
      plen_r <= '0;
      hi_r   <= '0;
      moff_r <= '0;
      stop_r <= 1'b0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      cs_r   <= cs_nxt;
      cbl_r  <= cbl_nxt;
      plen_r <= plen_nxt;
      hi_r   <= hi_nxt;
      moff_r <= moff_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

>>> hdl/lzssd_cmdq.sv
`timescale 1ns / 1ps
module lzssd_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lzssd_pkg::cmd_t push_cmd,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output lzssd_pkg::cmd_t head
);

  localparam int unsigned PW = $clog2(lzssd_pkg::CMDQ_DEPTH);

  lzssd_pkg::cmd_t mem_r [lzssd_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign ready = cnt_r != (PW+1)'(lzssd_pkg::CMDQ_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/lzssd_back.sv
`timescale 1ns / 1ps
module lzssd_back #(
  parameter int unsigned WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [23:0]     limit,
  input  logic            q_valid,
  input  lzssd_pkg::cmd_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte_a,
  output logic [7:0]      out_byte_b,
  output logic [7:0]      out_byte_c,
  output logic [7:0]      out_byte_d,
  output logic [2:0]      out_count,
  output logic            out_end_of_stream,
  output logic [1:0]      out_error_code,
  output logic            out_run_last
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COPY = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt, src_r, src_nxt;
  logic [23:0]   bw_r, bw_nxt;
  logic          stop_r, stop_nxt;
  logic [8:0]    li_r, li_nxt, lw_r, lw_nxt;
  logic          pv_r, pv_nxt, byp_r, byp_nxt;
  logic [7:0]    bypd_r, bypd_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          eos_r, eos_nxt, last_r, last_nxt;
  logic [7:0]    pack_r [lzssd_pkg::LANES];
  logic [7:0]    pack_nxt [lzssd_pkg::LANES];
  logic [2:0]    pcnt_r, pcnt_nxt;

  logic          adv;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata, cb;
  logic [23:0]   bw_e;
  logic [AW-1:0] wp_e;
  logic          emit;
  logic [7:0]    e_bytes [lzssd_pkg::LANES];
  logic [2:0]    e_cnt;
  logic          e_eos, e_last;
  logic [1:0]    e_err;

  logic [7:0]    ob_r [lzssd_pkg::LANES];
  logic [2:0]    ocnt_r;
  logic          oeos_r, olast_r, ov_r;
  logic [1:0]    oerr_r;

  lzssd_ram #(.W(8), .D(WINDOW_DEPTH)) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(src_r),
    .rdata(ram_rdata)
  );

  assign adv = !ov_r || !out_stall;

  always_comb begin
    st_nxt   = st_r;
    wpos_nxt = wpos_r;
    src_nxt  = src_r;
    bw_nxt   = bw_r;
    stop_nxt = stop_r;
    li_nxt   = li_r;
    lw_nxt   = lw_r;
    pv_nxt   = 1'b0;
    err_nxt  = err_r;
    eos_nxt  = eos_r;
    last_nxt = last_r;
    pack_nxt = pack_r;
    pcnt_nxt = pcnt_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wpos_r;
    ram_wdata = '0;
    cb        = byp_r ? bypd_r : ram_rdata;
    q_pop     = 1'b0;
    emit      = 1'b0;
    e_bytes   = pack_r;
    e_cnt     = pcnt_r;
    e_eos     = 1'b0;
    e_err     = lzssd_pkg::ERR_NONE;
    e_last    = 1'b0;
    bw_e      = q_head.first ? 24'd0 : bw_r;
    wp_e      = q_head.first ? '0 : wpos_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.first || !stop_r) begin
            stop_nxt = 1'b0;
            wpos_nxt = wp_e;
            bw_nxt   = bw_e;
            err_nxt  = lzssd_pkg::ERR_NONE;
            eos_nxt  = q_head.eos;
            last_nxt = q_head.last;
            st_nxt   = S_DONE;
            case (q_head.kind)
              lzssd_pkg::K_LIT: begin
                if (bw_e >= limit) begin
                  err_nxt = lzssd_pkg::ERR_LIMIT;
                end else begin
                  ram_we      = 1'b1;
                  ram_waddr   = wp_e;
                  ram_wdata   = q_head.data;
                  pack_nxt[0] = q_head.data;
                  pcnt_nxt    = 3'd1;
                  wpos_nxt    = wp_e + AW'(1);
                  bw_nxt      = bw_e + 24'd1;
                end
              end
              lzssd_pkg::K_MATCH: begin
                if ({12'd0, q_head.off} > bw_e) begin
                  err_nxt = lzssd_pkg::ERR_REF;
                end else begin
                  src_nxt = wp_e - AW'(q_head.off);
                  li_nxt  = q_head.len;
                  lw_nxt  = q_head.len;
                  st_nxt  = S_COPY;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_COPY: begin
        // write stage: the byte from the previous read lands in history and the pack
        if (pv_r) begin
          if (bw_r >= limit) begin
            err_nxt = lzssd_pkg::ERR_LIMIT;
            st_nxt  = S_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = cb;
            if (pcnt_r == 3'(lzssd_pkg::LANES)) begin
              emit        = 1'b1;
              e_cnt       = pcnt_r;
              pack_nxt    = '{default: 8'd0};
              pack_nxt[0] = cb;
              pcnt_nxt    = 3'd1;
            end else begin
              pack_nxt[pcnt_r[1:0]] = cb;
              pcnt_nxt              = pcnt_r + 3'd1;
            end
            wpos_nxt = wpos_r + AW'(1);
            bw_nxt   = bw_r + 24'd1;
            lw_nxt   = lw_r - 9'd1;
            if (lw_r == 9'd1) begin
              st_nxt = S_DONE;
            end
          end
        end
        // read stage
        if (li_r != 9'd0 && st_nxt == S_COPY) begin
          ram_re  = 1'b1;
          src_nxt = src_r + AW'(1);
          li_nxt  = li_r - 9'd1;
          pv_nxt  = 1'b1;
        end
      end
      S_DONE: begin
        e_cnt  = pcnt_r;
        e_eos  = (err_r == lzssd_pkg::ERR_NONE) && eos_r;
        e_err  = (err_r != lzssd_pkg::ERR_NONE) ? err_r :
                 (!eos_r && last_r) ? lzssd_pkg::ERR_EARLY : lzssd_pkg::ERR_NONE;
        e_last = 1'b1;
        emit   = (pcnt_r != 3'd0) || (err_r != lzssd_pkg::ERR_NONE) || eos_r || last_r;
        stop_nxt = (err_r != lzssd_pkg::ERR_NONE) || eos_r || last_r;
        pack_nxt = '{default: 8'd0};
        pcnt_nxt = 3'd0;
        st_nxt   = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (!adv) begin
      q_pop  = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
    end
    // a read issued on the same edge as a write to that address sees old data
    byp_nxt  = ram_we && ram_re && (ram_waddr == src_r);
    bypd_nxt = ram_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      wpos_r <= '0;
      bw_r   <= '0;
      stop_r <= 1'b0;
      pv_r   <= 1'b0;
      byp_r  <= 1'b0;
      pcnt_r <= '0;
      pack_r <= '{default: 8'd0};
      err_r  <= lzssd_pkg::ERR_NONE;
      eos_r  <= 1'b0;
      last_r <= 1'b0;
      ov_r   <= 1'b0;
    end else if (adv) begin
      st_r   <= st_nxt;
      wpos_r <= wpos_nxt;
      bw_r   <= bw_nxt;
      stop_r <= stop_nxt;
      pv_r   <= pv_nxt;
      byp_r  <= byp_nxt;
      pcnt_r <= pcnt_nxt;
      pack_r <= pack_nxt;
      err_r  <= err_nxt;
      eos_r  <= eos_nxt;
      last_r <= last_nxt;
      ov_r   <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      src_r  <= src_nxt;
      li_r   <= li_nxt;
      lw_r   <= lw_nxt;
      bypd_r <= bypd_nxt;
      if (emit) begin
        ob_r    <= e_bytes;
        ocnt_r  <= e_cnt;
        oeos_r  <= e_eos;
        oerr_r  <= e_err;
        olast_r <= e_last;
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_byte_a        = ob_r[0];
  assign out_byte_b        = ob_r[1];
  assign out_byte_c        = ob_r[2];
  assign out_byte_d        = ob_r[3];
  assign out_count         = ocnt_r;
  assign out_end_of_stream = oeos_r;
  assign out_error_code    = oerr_r;
  assign out_run_last      = olast_r;

endmodule

>>> hdl/lzss_stream_decompressor_unit.sv
`timescale 1ns / 1ps
// LZSS stream decompressor with a WINDOW_DEPTH-byte history.
// Input channel (in_valid / in_stall): one compressed byte per transaction,
// in_first opens a new stream, in_last marks the final available byte.
// Result channel (out_valid / out_stall): up to four decoded bytes per
// transaction plus count, end-of-stream, error code and run_last, which marks
// the final result caused by one input byte.
// Config channel (cfg_valid / cfg_ready): writes output_limit; always ready.
// A parser takes one byte per cycle while the queue has room, decodes flags and
// words into commands and pushes them into a four-entry queue. The copy engine
// pops one command at a time; a match reads one history byte per cycle through
// the single-port-read RAM while the result channel is not stalled.
// Reset clears the parser, queue and engine control state except the copy
// counters, and sets output_limit to 65536; history RAM content is not cleared.
// A stalled result holds the engine in place; the queue then fills and
// in_stall rises.
module lzss_stream_decompressor_unit #(
  parameter int unsigned WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_a,
  output logic [7:0]  out_byte_b,
  output logic [7:0]  out_byte_c,
  output logic [7:0]  out_byte_d,
  output logic [2:0]  out_count,
  output logic        out_end_of_stream,
  output logic [1:0]  out_error_code,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_output_limit
);

  logic [23:0]     limit_r;
  logic            q_push, q_ready, q_pop, q_valid;
  lzssd_pkg::cmd_t q_cmd, q_head;

  // config write lands immediately; the block is idle by contract
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lzssd_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_output_limit;
    end
  end

  lzssd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte (in_byte),
    .in_first(in_first),
    .in_last (in_last),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  lzssd_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .ready   (q_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  lzssd_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .limit            (limit_r),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_a       (out_byte_a),
    .out_byte_b       (out_byte_b),
    .out_byte_c       (out_byte_c),
    .out_byte_d       (out_byte_d),
    .out_count        (out_count),
    .out_end_of_stream(out_end_of_stream),
    .out_error_code   (out_error_code),
    .out_run_last     (out_run_last)
  );

endmodule

>>> hdl/lzssd_checker.sv
`timescale 1ns / 1ps
module lzssd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_count,
  input logic       out_end_of_stream,
  input logic [1:0] out_error_code,
  input logic       out_run_last
);

  // a result that is not the last of its byte is a full pack with no status
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> out_count == 3'd4 && !out_end_of_stream
      && out_error_code == lzssd_pkg::ERR_NONE)
    else $error("mid-run result not a full data pack");

  // an empty result exists only to carry status
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == 3'd0 |-> out_run_last
      && (out_end_of_stream || out_error_code != lzssd_pkg::ERR_NONE))
    else $error("empty result without status");

  // end of stream and an error never share a result
  a_eos_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_stream |-> out_error_code == lzssd_pkg::ERR_NONE)
    else $error("end of stream reported with an error");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count) && $stable(out_run_last))
    else $error("stalled result changed");

endmodule

bind lzss_stream_decompressor_unit lzssd_checker u_lzssd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_count        (out_count),
  .out_end_of_stream(out_end_of_stream),
  .out_error_code   (out_error_code),
  .out_run_last     (out_run_last)
);
